// ----- design/sbhr_pkg.sv -----
// Shared constants of the spectrum bar history renderer: widths, defaults, register map.
package sbhr_pkg;

	localparam int MATRIX_WIDTH_DEF  = 16;
	localparam int MATRIX_HEIGHT_DEF = 8;
	localparam int HISTORY_DEPTH_DEF = 16;

	localparam int BAND_INDEX_W  = 4;
	localparam int BAND_HEIGHT_W = 4;
	localparam int LED_INDEX_W   = 7;
	localparam int PIXEL_W       = 8;
	localparam int HIST_LEN_W    = 5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_LENGTH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_HUE        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MID_HUE        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_HUE       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SATURATION     = 3'd5;

	localparam logic [PIXEL_W-1:0]    BRIGHTNESS_RST     = 8'd255;
	localparam logic [HIST_LEN_W-1:0] HISTORY_LENGTH_RST = 5'd4;
	localparam logic [PIXEL_W-1:0]    LOW_HUE_RST        = 8'd96;
	localparam logic [PIXEL_W-1:0]    MID_HUE_RST        = 8'd64;
	localparam logic [PIXEL_W-1:0]    HIGH_HUE_RST       = 8'd0;
	localparam logic [PIXEL_W-1:0]    SATURATION_RST     = 8'd255;

	// 0.9 in Q16: floor(b*9/10) == (b*58986) >> 16 for every 8-bit b
	localparam logic [15:0] NINE_TENTHS_Q16 = 16'd58986;

	// row bands of the hue
	localparam int LOW_ROW_LAST = 4;
	localparam int MID_ROW_LAST = 6;

endpackage

// ----- design/sbhr_ifs.sv -----
// Valid/ready channel interfaces for band items and pixel results.
interface sbhr_band_if;
	logic                               valid;
	logic                               ready;
	logic [sbhr_pkg::BAND_INDEX_W-1:0]  band_index;
	logic [sbhr_pkg::BAND_HEIGHT_W-1:0] band_height;
	logic                               frame_end;

	modport source(output valid, band_index, band_height, frame_end, input ready);
	modport sink(input valid, band_index, band_height, frame_end, output ready);
endinterface

interface sbhr_pixel_if;
	logic                             valid;
	logic                             ready;
	logic [sbhr_pkg::LED_INDEX_W-1:0] led_index;
	logic [sbhr_pkg::PIXEL_W-1:0]     pixel_hue;
	logic [sbhr_pkg::PIXEL_W-1:0]     pixel_saturation;
	logic [sbhr_pkg::PIXEL_W-1:0]     pixel_brightness;
	logic                             column_done;

	modport source(output valid, led_index, pixel_hue, pixel_saturation, pixel_brightness,
		column_done, input ready);
	modport sink(input valid, led_index, pixel_hue, pixel_saturation, pixel_brightness,
		column_done, output ready);
endinterface

// ----- design/spectrum_bar_history_renderer.sv -----
// Spectrum bar renderer with fading frame history for a serpentine LED matrix.
//
// Channels: band (sink) takes one spectrum band per transfer: column, bar height and a
// frame_end flag. pixel (source) gives MATRIX_HEIGHT HSV pixels per in-range band, bottom
// row first, with the serpentine chain position; column_done marks the top row.
// Configuration: write cfg_we with cfg_index/cfg_data while idle; no read-back.
// Sequence: one band at a time. A band that continues a frame takes its transfer, a
// write of its height into the newest history row, frames_held-1 history reads from the
// newest older frame back and a wait for the last read to come in, then MATRIX_HEIGHT
// pixels of output. The first band of a frame first zeroes the new history row, runs
// the shift-subtract divider for the fade step and scales it.
// Reset clears all control state and loads the register defaults; the history memory
// is not cleared, every row is zeroed when its frame opens.
// A stalled receiver holds the pixel register and stops output; the next band is taken
// once the last pixel of the column has moved into the output register.
module spectrum_bar_history_renderer #(
	parameter int MATRIX_WIDTH  = sbhr_pkg::MATRIX_WIDTH_DEF,
	parameter int MATRIX_HEIGHT = sbhr_pkg::MATRIX_HEIGHT_DEF,
	parameter int HISTORY_DEPTH = sbhr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sbhr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbhr_pkg::CFG_DATA_W-1:0]  cfg_data,
	sbhr_band_if.sink                        band,
	sbhr_pixel_if.source                     pixel
);

	localparam int CW    = $clog2(MATRIX_WIDTH);
	localparam int SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW    = $clog2(HISTORY_DEPTH + 1);
	localparam int RW    = $clog2(MATRIX_HEIGHT);
	localparam int HW    = sbhr_pkg::BAND_HEIGHT_W;
	localparam int PW    = sbhr_pkg::PIXEL_W;
	localparam int DEPTH = HISTORY_DEPTH * MATRIX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	// configuration registers
	logic [PW-1:0]                   brightness_q;
	logic [sbhr_pkg::HIST_LEN_W-1:0] history_length_q;
	logic [PW-1:0]                   low_hue_q;
	logic [PW-1:0]                   mid_hue_q;
	logic [PW-1:0]                   high_hue_q;
	logic [PW-1:0]                   saturation_q;

	// control state
	logic [2:0]    state_q;
	logic          frame_open_q;
	logic [SW-1:0] newest_slot_q;
	logic [FW-1:0] frames_q;
	logic [PW-1:0] step_q;
	logic [PW-1:0] top_bri_q;
	logic [CW-1:0] clr_col_q;
	logic [2:0]    div_cnt_q;
	logic [FW-1:0] rem_q;
	logic [PW-1:0] div_num_q;
	logic [SW-1:0] rd_slot_q;
	logic [FW-1:0] age_q;
	logic [PW-1:0] bri_tag_q;
	logic          rd_vld_s1;
	logic [RW-1:0] row_q;

	// band payload
	logic [sbhr_pkg::BAND_INDEX_W-1:0] col_q;
	logic [HW-1:0]                     h_q;
	logic                              col_ok_q;

	// history of older frames per row, row 0 at index 0
	logic          lit_old_q [MATRIX_HEIGHT];
	logic [PW-1:0] bri_old_q [MATRIX_HEIGHT];

	// history memory
	logic [HW-1:0] hist_mem [DEPTH];
	logic [HW-1:0] rd_data_s1;
	logic [PW-1:0] bri_s1;

	// output register
	logic                                 out_vld_q;
	logic [sbhr_pkg::LED_INDEX_W-1:0]     led_q;
	logic [PW-1:0]                        hue_q;
	logic [PW-1:0]                        sat_q;
	logic [PW-1:0]                        bri_q;
	logic                                 done_q;

	logic          accept;
	logic [CW-1:0] col_idx;
	logic [HW-1:0] h_clip;
	logic          band_col_ok;
	logic [7:0]    lim8;
	logic [7:0]    fs_inc8;
	logic [FW-1:0] fs_next;
	logic [SW-1:0] slot_next;
	logic [SW-1:0] rd_slot_prev;
	logic [23:0]   scaled_bri;
	logic [FW:0]   rem_sh;
	logic          rem_ge;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [HW-1:0] wr_data;
	logic          rd_issue;
	logic [AW-1:0] rd_addr;
	logic          emit_load;
	logic          row_cur;
	logic          row_lit;
	logic [PW-1:0] row_hue;
	logic [PW-1:0] row_bri;
	logic [15:0]   led_full;

	function automatic logic [AW-1:0] mem_addr(input logic [SW-1:0] slot,
		input logic [CW-1:0] col);
		mem_addr = AW'(int'(slot) * MATRIX_WIDTH + int'(col));
	endfunction

	assign band.ready = (state_q == ST_IDLE);
	assign accept     = band.valid & band.ready;

	assign col_idx     = CW'(col_q);
	assign band_col_ok = int'(band.band_index) < MATRIX_WIDTH;
	assign h_clip      = (int'(band.band_height) > MATRIX_HEIGHT) ?
		HW'(MATRIX_HEIGHT) : band.band_height;

	// frames held at the next opening: one more than now, up to the history length (zero taken as one, capped at depth)
	always_comb begin
		if (history_length_q == '0) begin
			lim8 = 8'd1;
		end else if (int'(history_length_q) > HISTORY_DEPTH) begin
			lim8 = 8'(HISTORY_DEPTH);
		end else begin
			lim8 = 8'(history_length_q);
		end
		fs_inc8 = 8'(frames_q) + 8'd1;
		fs_next = (fs_inc8 > lim8) ? FW'(lim8) : FW'(fs_inc8);
	end

	assign slot_next    = (int'(newest_slot_q) == HISTORY_DEPTH - 1) ? '0 : newest_slot_q + 1'b1;
	assign rd_slot_prev = (rd_slot_q == '0) ? SW'(HISTORY_DEPTH - 1) : rd_slot_q - 1'b1;
	assign scaled_bri   = 24'(brightness_q) * 24'(sbhr_pkg::NINE_TENTHS_Q16);

	// one restoring division step: quotient bits shift into div_num_q from the right
	assign rem_sh = {rem_q, div_num_q[PW-1]};
	assign rem_ge = rem_sh >= {1'b0, frames_q};

	// memory access: clearing sweep and band write share the write port
	assign wr_en    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign wr_addr  = mem_addr(newest_slot_q, (state_q == ST_CLEAR) ? clr_col_q : col_idx);
	assign wr_data  = (state_q == ST_CLEAR) ? '0 : h_q;
	assign rd_issue = (state_q == ST_READ) && (age_q < frames_q);
	assign rd_addr  = mem_addr(rd_slot_q, col_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
		if (rd_issue) begin
			rd_data_s1 <= hist_mem[rd_addr];
			bri_s1     <= bri_tag_q;
		end
	end

	// pixel of the current row: current frame wins, else newest covering older frame
	assign emit_load = (state_q == ST_EMIT) && (!out_vld_q || pixel.ready);
	assign row_cur   = int'(row_q) < int'(h_q);
	assign row_lit   = row_cur || lit_old_q[0];
	assign row_bri   = row_cur ? brightness_q : bri_old_q[0];

	always_comb begin
		if (int'(row_q) > sbhr_pkg::MID_ROW_LAST) begin
			row_hue = high_hue_q;
		end else if (int'(row_q) > sbhr_pkg::LOW_ROW_LAST) begin
			row_hue = mid_hue_q;
		end else begin
			row_hue = low_hue_q;
		end
		// odd columns run upward, even columns downward
		if (col_idx[0]) begin
			led_full = 16'(MATRIX_HEIGHT * (MATRIX_WIDTH - 1 - int'(col_idx)) + int'(row_q));
		end else begin
			led_full = 16'(MATRIX_HEIGHT * (MATRIX_WIDTH - int'(col_idx)) - 1 - int'(row_q));
		end
	end

	// configuration writes; indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q     <= sbhr_pkg::BRIGHTNESS_RST;
			history_length_q <= sbhr_pkg::HISTORY_LENGTH_RST;
			low_hue_q        <= sbhr_pkg::LOW_HUE_RST;
			mid_hue_q        <= sbhr_pkg::MID_HUE_RST;
			high_hue_q       <= sbhr_pkg::HIGH_HUE_RST;
			saturation_q     <= sbhr_pkg::SATURATION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbhr_pkg::REG_BRIGHTNESS:     brightness_q     <= cfg_data;
				sbhr_pkg::REG_HISTORY_LENGTH: history_length_q <=
					cfg_data[sbhr_pkg::HIST_LEN_W-1:0];
				sbhr_pkg::REG_LOW_HUE:        low_hue_q        <= cfg_data;
				sbhr_pkg::REG_MID_HUE:        mid_hue_q        <= cfg_data;
				sbhr_pkg::REG_HIGH_HUE:       high_hue_q       <= cfg_data;
				sbhr_pkg::REG_SATURATION:     saturation_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// band payload, taken on a transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q    <= band.band_index;
			h_q      <= h_clip;
			col_ok_q <= band_col_ok;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			frame_open_q  <= 1'b0;
			newest_slot_q <= '0;
			frames_q      <= '0;
			step_q        <= '0;
			top_bri_q     <= '0;
			clr_col_q     <= '0;
			div_cnt_q     <= '0;
			rem_q         <= '0;
			div_num_q     <= '0;
			rd_slot_q     <= '0;
			age_q         <= '0;
			bri_tag_q     <= '0;
			rd_vld_s1     <= 1'b0;
			row_q         <= '0;
		end else begin
			rd_vld_s1 <= rd_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						frame_open_q <= !band.frame_end;
						if (!frame_open_q) begin
							// open a frame: advance the ring, latch count and fade source
							newest_slot_q <= slot_next;
							frames_q      <= fs_next;
							div_num_q     <= scaled_bri[23:16];
							clr_col_q     <= '0;
							state_q       <= ST_CLEAR;
						end else begin
							state_q <= band_col_ok ? ST_WRITE : ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					clr_col_q <= clr_col_q + 1'b1;
					if (clr_col_q == CW'(MATRIX_WIDTH - 1)) begin
						div_cnt_q <= '0;
						rem_q     <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= rem_ge ? FW'(rem_sh - {1'b0, frames_q}) : FW'(rem_sh);
					div_num_q <= {div_num_q[PW-2:0], rem_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 3'd7) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					step_q    <= div_num_q;
					top_bri_q <= PW'((frames_q - 1'b1) * div_num_q);
					state_q   <= col_ok_q ? ST_WRITE : ST_IDLE;
				end
				ST_WRITE: begin
					rd_slot_q <= (newest_slot_q == '0) ?
						SW'(HISTORY_DEPTH - 1) : newest_slot_q - 1'b1;
					age_q     <= FW'(1);
					bri_tag_q <= top_bri_q;
					state_q   <= ST_READ;
				end
				ST_READ: begin
					// walk from the newest older frame back; brightness drops a step per frame
					if (rd_issue) begin
						rd_slot_q <= rd_slot_prev;
						age_q     <= age_q + 1'b1;
						bri_tag_q <= bri_tag_q - step_q;
					end else if (!rd_vld_s1) begin
						row_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						row_q <= row_q + 1'b1;
						if (row_q == RW'(MATRIX_HEIGHT - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-row history lanes: first hit (newest frame) holds; shift down as rows go out
	always_ff @(posedge clk) begin
		for (int r = 0; r < MATRIX_HEIGHT; r++) begin
			if (state_q == ST_WRITE) begin
				lit_old_q[r] <= 1'b0;
			end else if (rd_vld_s1) begin
				if (!lit_old_q[r] && (int'(rd_data_s1) > r)) begin
					lit_old_q[r] <= 1'b1;
					bri_old_q[r] <= bri_s1;
				end
			end else if (emit_load) begin
				if (r == MATRIX_HEIGHT - 1) begin
					lit_old_q[r] <= 1'b0;
				end else begin
					lit_old_q[r] <= lit_old_q[r+1];
					bri_old_q[r] <= bri_old_q[r+1];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_load) begin
			out_vld_q <= 1'b1;
		end else if (pixel.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			led_q  <= led_full[sbhr_pkg::LED_INDEX_W-1:0];
			hue_q  <= row_lit ? row_hue : '0;
			sat_q  <= row_lit ? saturation_q : '0;
			bri_q  <= row_lit ? row_bri : '0;
			done_q <= (row_q == RW'(MATRIX_HEIGHT - 1));
		end
	end

	assign pixel.valid            = out_vld_q;
	assign pixel.led_index        = led_q;
	assign pixel.pixel_hue        = hue_q;
	assign pixel.pixel_saturation = sat_q;
	assign pixel.pixel_brightness = bri_q;
	assign pixel.column_done      = done_q;

endmodule
